### rtl/mltq_pkg.sv
// Shared constants, types and codes of the multi-level task queue.
package mltq_pkg;

    localparam int NUM_LEVELS  = 2;
    localparam int LEVEL_DEPTH = 256;
    localparam int TAG_BITS    = 16;
    localparam int NODE_W      = 8;

    localparam int LVL_W   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int PTR_W   = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CNT_W   = $clog2(LEVEL_DEPTH + 1);
    localparam int ADDR_W  = LVL_W + PTR_W;
    localparam int RAM_DEPTH = 1 << ADDR_W;
    localparam int LOAD_W  = CNT_W + NUM_LEVELS - 1;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_PULL  = 2'd1,
        OP_STEAL = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LOOK = 2'b10
    } state_t;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic                stealable;
        logic [NODE_W-1:0]   node;
    } entry_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic                task_valid;
        logic [TAG_BITS-1:0] tag;
        logic [LVL_W-1:0]    level;
        logic [NODE_W-1:0]   node;
        logic                push_accepted;
        logic                push_overflow;
    } result_t;

    typedef logic [NUM_LEVELS-1:0][CNT_W-1:0] counts_t;

endpackage

### rtl/mltq_entry_ram.sv
// Entry memory: one ring of entries per level, one write and one registered read port.
module mltq_entry_ram
    import mltq_pkg::*;
(
    input  logic     clk,
    input  ram_req_t req,
    output entry_t   rd_data
);

    entry_t mem [RAM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data <= mem[req.raddr];
        end
    end

endmodule

### rtl/mltq_ctrl.sv
// Request sequencer: ring pointers, level counts and the pull/steal scan.
module mltq_ctrl
    import mltq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          opcode,
    input  logic [TAG_BITS-1:0] task_tag,
    input  logic [LVL_W-1:0]    task_level,
    input  logic                task_stealable,
    input  logic                already_enqueued,
    input  logic [NODE_W-1:0]   node_id,
    input  entry_t              rd_data,
    output ram_req_t            ram_req,
    output logic                busy,
    output logic                done,
    output result_t             result,
    output counts_t             counts
);

    state_t              state_reg, state_next;
    logic [PTR_W-1:0]    head_reg [NUM_LEVELS];
    logic [PTR_W-1:0]    head_next [NUM_LEVELS];
    logic [PTR_W-1:0]    tail_reg [NUM_LEVELS];
    logic [PTR_W-1:0]    tail_next [NUM_LEVELS];
    counts_t             count_reg, count_next;
    logic [LVL_W-1:0]    cur_reg, cur_next;
    logic                pull_reg, pull_next;
    logic                done_reg, done_next;
    result_t             res_reg, res_next;

    logic                first_found, next_found;
    logic [LVL_W-1:0]    first_lvl, next_lvl;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Lowest non-empty level, from level 0 and from the level after the current one.
    always_comb
    begin
        first_found = 1'b0;
        first_lvl   = '0;
        next_found  = 1'b0;
        next_lvl    = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--)
        begin
            if (count_reg[l] != '0)
            begin
                first_found = 1'b1;
                first_lvl   = LVL_W'(l);
                if (l > int'(cur_reg))
                begin
                    next_found = 1'b1;
                    next_lvl   = LVL_W'(l);
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        pull_next  = pull_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        ram_req    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    res_next = '0;
                    if (opcode == OP_PUSH)
                    begin
                        done_next = 1'b1;
                        if (!already_enqueued && int'(task_level) < NUM_LEVELS)
                        begin
                            if (int'(count_reg[task_level]) >= LEVEL_DEPTH)
                            begin
                                res_next.push_overflow = 1'b1;
                            end
                            else
                            begin
                                ram_req.we             = 1'b1;
                                ram_req.waddr          = {task_level, tail_reg[task_level]};
                                ram_req.wdata.tag      = task_tag;
                                ram_req.wdata.stealable = task_stealable;
                                ram_req.wdata.node     = node_id;
                                tail_next[task_level]  = advance(tail_reg[task_level]);
                                count_next[task_level] = count_reg[task_level] + 1'b1;
                                res_next.push_accepted = 1'b1;
                            end
                        end
                    end
                    else if (opcode == OP_PULL || opcode == OP_STEAL)
                    begin
                        pull_next = (opcode == OP_PULL);
                        if (first_found)
                        begin
                            ram_req.re    = 1'b1;
                            ram_req.raddr = {first_lvl, head_reg[first_lvl]};
                            cur_next      = first_lvl;
                            state_next    = ST_LOOK;
                        end
                        else
                        begin
                            done_next = 1'b1;
                        end
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end

            ST_LOOK:
            begin
                head_next[cur_reg] = advance(head_reg[cur_reg]);
                if (pull_reg || rd_data.stealable)
                begin
                    count_next[cur_reg] = count_reg[cur_reg] - 1'b1;
                    res_next.task_valid = 1'b1;
                    res_next.tag        = rd_data.tag;
                    res_next.level      = cur_reg;
                    res_next.node       = rd_data.node;
                    done_next           = 1'b1;
                    state_next          = ST_IDLE;
                end
                else
                begin
                    // Rotate the head to the tail of its own level.
                    ram_req.we         = 1'b1;
                    ram_req.waddr      = {cur_reg, tail_reg[cur_reg]};
                    ram_req.wdata      = rd_data;
                    tail_next[cur_reg] = advance(tail_reg[cur_reg]);
                    if (next_found)
                    begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = {next_lvl, head_reg[next_lvl]};
                        cur_next      = next_lvl;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            cur_reg   <= '0;
            pull_reg  <= 1'b0;
            done_reg  <= 1'b0;
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                head_reg[l] <= '0;
                tail_reg[l] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cur_reg   <= cur_next;
            pull_reg  <= pull_next;
            done_reg  <= done_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;
    assign counts = count_reg;

endmodule

### rtl/multi_level_task_queue.sv
// Top level of the multi-level task queue: node register, status and port wiring.
//
//  channel   | signals                                         | handshake
//  ----------+-------------------------------------------------+-----------------------
//  request   | opcode, task_tag, task_level, task_stealable,   | start & !busy
//            | already_enqueued                                |
//  result    | task_valid, out_tag, out_level, out_node,       | done, one cycle wide
//            | push_accepted, push_overflow, all_empty,        |
//            | load_estimate                                   |
//  config    | node_id_wdata                                   | node_id_we
//
// A push's result appears on the cycle after it is accepted. A pull reads the head
// entry through the registered read port of the entry memory; a steal reads one head
// per level visited. A pull or steal that finds every level empty answers like a push,
// on the cycle after it is accepted. Reset clears the pointers, the level counts and
// the node number; the entry memory is not cleared, since only written entries are
// ever read. Results cannot be stalled: done is high for exactly one cycle per
// request, and a new request may be accepted in that same cycle.
module multi_level_task_queue
    import mltq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          opcode,
    input  logic [TAG_BITS-1:0] task_tag,
    input  logic [LVL_W-1:0]    task_level,
    input  logic                task_stealable,
    input  logic                already_enqueued,
    input  logic                node_id_we,
    input  logic [NODE_W-1:0]   node_id_wdata,
    output logic                done,
    output logic                task_valid,
    output logic [TAG_BITS-1:0] out_tag,
    output logic [LVL_W-1:0]    out_level,
    output logic [NODE_W-1:0]   out_node,
    output logic                push_accepted,
    output logic                push_overflow,
    output logic                all_empty,
    output logic [LOAD_W-1:0]   load_estimate
);

    logic [NODE_W-1:0] node_id_reg;
    ram_req_t          ram_req;
    entry_t            rd_data;
    result_t           result;
    counts_t           counts;
    logic [LOAD_W-1:0] load_sum;
    logic              any_held;

    // The node number is stamped onto every task as it is pushed into the memory.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg <= '0;
        end
        else if (node_id_we)
        begin
            node_id_reg <= node_id_wdata;
        end
    end

    mltq_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .opcode           (opcode),
        .task_tag         (task_tag),
        .task_level       (task_level),
        .task_stealable   (task_stealable),
        .already_enqueued (already_enqueued),
        .node_id          (node_id_reg),
        .rd_data          (rd_data),
        .ram_req          (ram_req),
        .busy             (busy),
        .done             (done),
        .result           (result),
        .counts           (counts)
    );

    mltq_entry_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    // The counts are updated on the same edge that raises done, so the status below
    // already describes the queue after the request. Higher priority levels weigh more:
    // level l counts 2^(levels-1-l) per entry.
    always_comb
    begin
        load_sum = '0;
        any_held = 1'b0;
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            load_sum = load_sum + (LOAD_W'(counts[l]) << (NUM_LEVELS - 1 - l));
            any_held = any_held | (counts[l] != '0);
        end
    end

    assign task_valid    = result.task_valid;
    assign out_tag       = result.tag;
    assign out_level     = result.level;
    assign out_node      = result.node;
    assign push_accepted = result.push_accepted;
    assign push_overflow = result.push_overflow;
    assign all_empty     = !any_held;
    assign load_estimate = load_sum;

endmodule
